// ===== design/crcs_pkg.sv =====
// Package for the cluster ROI cut selector: field widths, register map,
// reset values and the structs shared by the register file, cut logic and top.
// No dependencies.
`default_nettype none

package crcs_pkg;

    localparam int NUM_BINS  = 4;
    localparam int ETA_W     = 12;
    localparam int PHI_W     = 12;
    localparam int EDGE_W    = 12;
    localparam int ENERGY_W  = 15;
    localparam int LIMIT_W   = 11;
    localparam int BINS_W    = 3;
    localparam int PACK_W    = 60;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    // Register indexes (byte address = 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_ROI_ETA_LIMIT     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ETA_CUT           = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PHI_CUT           = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BINS_IN_USE       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ETA_EDGES         = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ENERGY_THRESHOLDS = 3'd5;

    localparam logic [LIMIT_W-1:0] ROI_ETA_LIMIT_RST     = 11'd665;
    localparam logic [ETA_W-1:0]   ETA_CUT_RST           = 12'd26;
    localparam logic [PHI_W-1:0]   PHI_CUT_RST           = 12'd65;
    localparam logic [BINS_W-1:0]  BINS_IN_USE_RST       = 3'd4;
    localparam logic [PACK_W-1:0]  ETA_EDGES_RST         = '0;
    localparam logic [PACK_W-1:0]  ENERGY_THRESHOLDS_RST = '0;

    typedef struct packed {
        logic [LIMIT_W-1:0] roi_eta_limit;
        logic [ETA_W-1:0]   eta_cut;
        logic [PHI_W-1:0]   phi_cut;
        logic [BINS_W-1:0]  bins_in_use;
        logic [PACK_W-1:0]  eta_edges;
        logic [PACK_W-1:0]  energy_thresholds;
    } cfg_t;

    typedef struct packed {
        logic                    prev_passed;
        logic signed [ETA_W-1:0] roi_eta;
        logic signed [PHI_W-1:0] roi_phi;
        logic signed [ETA_W-1:0] cluster_eta;
        logic signed [PHI_W-1:0] cluster_phi;
        logic [ENERGY_W-1:0]     cluster_energy;
    } item_t;

    typedef struct packed {
        logic             accept;
        logic [2:0]       cuts_passed;
        logic [1:0]       eta_bin;
        logic             bin_found;
        logic [PHI_W-1:0] delta_phi;
    } res_t;

endpackage

`default_nettype wire

// ===== design/crcs_cfg_regs.sv =====
// Configuration register file with an APB-style slave port.
// Depends on crcs_pkg for the register map, reset values and cfg_t.
`default_nettype none

module crcs_cfg_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [crcs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [crcs_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [crcs_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output crcs_pkg::cfg_t                          cfg
);

    crcs_pkg::cfg_t                        cfg_reg;
    logic                                  wr_en;
    logic [crcs_pkg::REG_IDX_W-1:0]        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[crcs_pkg::CFG_ADDR_W-1:crcs_pkg::CFG_ADDR_W-crcs_pkg::REG_IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.roi_eta_limit     <= crcs_pkg::ROI_ETA_LIMIT_RST;
            cfg_reg.eta_cut           <= crcs_pkg::ETA_CUT_RST;
            cfg_reg.phi_cut           <= crcs_pkg::PHI_CUT_RST;
            cfg_reg.bins_in_use       <= crcs_pkg::BINS_IN_USE_RST;
            cfg_reg.eta_edges         <= crcs_pkg::ETA_EDGES_RST;
            cfg_reg.energy_thresholds <= crcs_pkg::ENERGY_THRESHOLDS_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                crcs_pkg::REG_ROI_ETA_LIMIT:
                    cfg_reg.roi_eta_limit <= pwdata[crcs_pkg::LIMIT_W-1:0];
                crcs_pkg::REG_ETA_CUT:
                    cfg_reg.eta_cut <= pwdata[crcs_pkg::ETA_W-1:0];
                crcs_pkg::REG_PHI_CUT:
                    cfg_reg.phi_cut <= pwdata[crcs_pkg::PHI_W-1:0];
                crcs_pkg::REG_BINS_IN_USE:
                    cfg_reg.bins_in_use <= pwdata[crcs_pkg::BINS_W-1:0];
                crcs_pkg::REG_ETA_EDGES:
                    cfg_reg.eta_edges <= pwdata[crcs_pkg::PACK_W-1:0];
                crcs_pkg::REG_ENERGY_THRESHOLDS:
                    cfg_reg.energy_thresholds <= pwdata[crcs_pkg::PACK_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            crcs_pkg::REG_ROI_ETA_LIMIT:
                prdata = crcs_pkg::CFG_DATA_W'(cfg_reg.roi_eta_limit);
            crcs_pkg::REG_ETA_CUT:
                prdata = crcs_pkg::CFG_DATA_W'(cfg_reg.eta_cut);
            crcs_pkg::REG_PHI_CUT:
                prdata = crcs_pkg::CFG_DATA_W'(cfg_reg.phi_cut);
            crcs_pkg::REG_BINS_IN_USE:
                prdata = crcs_pkg::CFG_DATA_W'(cfg_reg.bins_in_use);
            crcs_pkg::REG_ETA_EDGES:
                prdata = crcs_pkg::CFG_DATA_W'(cfg_reg.eta_edges);
            crcs_pkg::REG_ENERGY_THRESHOLDS:
                prdata = crcs_pkg::CFG_DATA_W'(cfg_reg.energy_thresholds);
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/crcs_cut_eval.sv =====
// Combinational cut chain: fiducial, delta eta, delta phi, eta bin, energy.
// Depends on crcs_pkg for cfg_t, item_t and res_t.
`default_nettype none

module crcs_cut_eval
(
    input  wire crcs_pkg::cfg_t  cfg,
    input  wire crcs_pkg::item_t item,
    output crcs_pkg::res_t       res
);

    logic signed [crcs_pkg::ETA_W:0]     reta_x;
    logic signed [crcs_pkg::ETA_W:0]     ceta_x;
    logic signed [crcs_pkg::ETA_W:0]     deta_x;
    logic        [crcs_pkg::ETA_W:0]     reta_abs;
    logic        [crcs_pkg::ETA_W:0]     ceta_abs_w;
    logic        [crcs_pkg::ETA_W:0]     deta_abs;
    logic        [crcs_pkg::EDGE_W-1:0]  ceta_abs;
    logic        [crcs_pkg::PHI_W-1:0]   phi_diff;
    logic        [crcs_pkg::PHI_W:0]     phi_wrap;
    logic        [crcs_pkg::PHI_W-1:0]   dphi;
    logic        [crcs_pkg::BINS_W-1:0]  nb;
    logic        [crcs_pkg::NUM_BINS-1:0] hit;
    logic        [1:0]                   bin;
    logic                                found;
    logic        [crcs_pkg::ENERGY_W-1:0] thr;
    logic        [crcs_pkg::EDGE_W-1:0]  lo;
    logic        [crcs_pkg::EDGE_W-1:0]  hi;
    logic                                fid_ok;
    logic                                eta_ok;
    logic                                phi_ok;
    logic                                energy_ok;

    always_comb
    begin
        reta_x     = {item.roi_eta[crcs_pkg::ETA_W-1], item.roi_eta};
        ceta_x     = {item.cluster_eta[crcs_pkg::ETA_W-1], item.cluster_eta};
        deta_x     = ceta_x - reta_x;
        reta_abs   = reta_x[crcs_pkg::ETA_W] ? 13'(-reta_x) : 13'(reta_x);
        ceta_abs_w = ceta_x[crcs_pkg::ETA_W] ? 13'(-ceta_x) : 13'(ceta_x);
        deta_abs   = deta_x[crcs_pkg::ETA_W] ? 13'(-deta_x) : 13'(deta_x);
        // |eta| tops out at 2048, which still fits the edge width
        ceta_abs   = ceta_abs_w[crcs_pkg::EDGE_W-1:0];

        phi_diff = item.cluster_phi - item.roi_phi;
        phi_wrap = 13'd4096 - {1'b0, phi_diff};
        dphi     = (phi_diff <= 12'd2048) ? phi_diff : phi_wrap[crcs_pkg::PHI_W-1:0];

        nb = (cfg.bins_in_use > crcs_pkg::BINS_W'(crcs_pkg::NUM_BINS))
           ? crcs_pkg::BINS_W'(crcs_pkg::NUM_BINS) : cfg.bins_in_use;

        for (int k = 0; k < crcs_pkg::NUM_BINS; k++)
        begin
            lo     = cfg.eta_edges[crcs_pkg::EDGE_W*k +: crcs_pkg::EDGE_W];
            hi     = cfg.eta_edges[crcs_pkg::EDGE_W*(k+1) +: crcs_pkg::EDGE_W];
            hit[k] = (crcs_pkg::BINS_W'(k) < nb) && (lo < ceta_abs) && (ceta_abs < hi);
        end

        // first matching bin wins: scan from the top so the lowest hit stays
        bin   = 2'd0;
        found = 1'b0;
        for (int k = crcs_pkg::NUM_BINS - 1; k >= 0; k--)
        begin
            if (hit[k])
            begin
                bin   = 2'(k);
                found = 1'b1;
            end
        end

        thr = cfg.energy_thresholds[crcs_pkg::ENERGY_W*bin +: crcs_pkg::ENERGY_W];

        fid_ok    = reta_abs <= {2'b00, cfg.roi_eta_limit};
        eta_ok    = deta_abs <= {1'b0, cfg.eta_cut};
        phi_ok    = dphi <= cfg.phi_cut;
        energy_ok = item.cluster_energy >= thr;

        res = '0;
        if (fid_ok)
        begin
            res.delta_phi = dphi;
            res.eta_bin   = bin;
            res.bin_found = found;
            if (eta_ok)
            begin
                res.cuts_passed = 3'd1;
                if (phi_ok)
                begin
                    res.cuts_passed = 3'd2;
                    if (found)
                    begin
                        res.cuts_passed = 3'd3;
                        if (energy_ok)
                        begin
                            res.cuts_passed = 3'd4;
                            res.accept      = item.prev_passed;
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/cluster_roi_cut_selector.sv =====
// Top level of the cluster ROI cut selector: stream ports, input and result
// registers around the cut logic. Depends on crcs_pkg, crcs_cfg_regs, crcs_cut_eval.
//
//   Channel   Dir   Handshake          Payload
//   s_*       in    s_tvalid/s_tready  candidate fields in s_tdata, prev_passed in s_tuser
//   m_*       out   m_tvalid/m_tready  result fields in m_tdata, accept in m_tuser
//   APB       in    psel/penable       register writes and reads, pready always high
//
// One candidate per cycle sustained while m_tready stays high; a candidate passes
// through the input register, then the result register after the cut chain.
// Reset clears both valid flags and loads register defaults. A stalled result
// holds the result register; the input register still takes a new
// transaction while the result stage is free or being drained in the same cycle.
`default_nettype none

module cluster_roi_cut_selector
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [11:0] roi_eta, [23:12] roi_phi, [35:24] cluster_eta,
    // [47:36] cluster_phi, [62:48] cluster_energy, [63] zero
    input  wire logic [63:0]                      s_tdata,
    // [0] prev_passed
    input  wire logic                             s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [2:0] cuts_passed, [4:3] eta_bin, [5] bin_found, [17:6] delta_phi,
    // [23:18] zero
    output logic      [23:0]                      m_tdata,
    // [0] accept
    output logic                                  m_tuser,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [crcs_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [crcs_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic      [crcs_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                                  pready
);

    crcs_pkg::cfg_t  cfg;
    crcs_pkg::item_t in_item_reg;
    crcs_pkg::res_t  eval_res;
    crcs_pkg::res_t  out_res_reg;
    logic            in_valid_reg;
    logic            in_valid_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            advance;
    logic            in_take;

    crcs_cfg_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crcs_cut_eval u_eval
    (
        .cfg  (cfg),
        .item (in_item_reg),
        .res  (eval_res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
        begin
            in_valid_next = s_tvalid;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.prev_passed    <= s_tuser;
            in_item_reg.roi_eta        <= s_tdata[11:0];
            in_item_reg.roi_phi        <= s_tdata[23:12];
            in_item_reg.cluster_eta    <= s_tdata[35:24];
            in_item_reg.cluster_phi    <= s_tdata[47:36];
            in_item_reg.cluster_energy <= s_tdata[62:48];
        end
        if (advance)
        begin
            out_res_reg <= eval_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.accept;
    assign m_tdata  = {6'd0, out_res_reg.delta_phi, out_res_reg.bin_found,
                       out_res_reg.eta_bin, out_res_reg.cuts_passed};

endmodule

`default_nettype wire

// ===== verif/cluster_roi_cut_selector_tb.sv =====
// Self-checking testbench for cluster_roi_cut_selector: drives candidates on the
// input stream, programs the cut registers over APB and checks every result.
// Depends on crcs_pkg and the cluster_roi_cut_selector RTL.

module cluster_roi_cut_selector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crcs_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    class cut_scoreboard;
        cfg_t cfg;
        res_t pending_results[$];
        int   mismatches;
        int   checked;
        int   accepted;
        int   depth_count[5];

        function new();
            cfg.roi_eta_limit     = ROI_ETA_LIMIT_RST;
            cfg.eta_cut           = ETA_CUT_RST;
            cfg.phi_cut           = PHI_CUT_RST;
            cfg.bins_in_use       = BINS_IN_USE_RST;
            cfg.eta_edges         = ETA_EDGES_RST;
            cfg.energy_thresholds = ENERGY_THRESHOLDS_RST;
            mismatches = 0;
            checked    = 0;
            accepted   = 0;
            foreach (depth_count[i])
                depth_count[i] = 0;
        endfunction

        function void write_register(logic [REG_IDX_W-1:0] idx, logic [63:0] value);
            case (idx)
                REG_ROI_ETA_LIMIT:     cfg.roi_eta_limit     = value[LIMIT_W-1:0];
                REG_ETA_CUT:           cfg.eta_cut           = value[ETA_W-1:0];
                REG_PHI_CUT:           cfg.phi_cut           = value[PHI_W-1:0];
                REG_BINS_IN_USE:       cfg.bins_in_use       = value[BINS_W-1:0];
                REG_ETA_EDGES:         cfg.eta_edges         = value[PACK_W-1:0];
                REG_ENERGY_THRESHOLDS: cfg.energy_thresholds = value[PACK_W-1:0];
                default: ;
            endcase
        endfunction

        function int sext12(logic [11:0] v);
            return v[11] ? int'(v) - 4096 : int'(v);
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function res_t evaluate_cut_chain(item_t c);
            res_t r;
            int   reta, rphi, ceta, cphi, diff, aeta, nb, lo, hi, thr, k;
            r    = '0;
            reta = sext12(c.roi_eta);
            rphi = sext12(c.roi_phi);
            ceta = sext12(c.cluster_eta);
            cphi = sext12(c.cluster_phi);
            if (magnitude(reta) <= int'(cfg.roi_eta_limit))
            begin
                diff = (cphi - rphi) & 'hFFF;
                r.delta_phi = 12'((diff <= 2048) ? diff : 4096 - diff);
                aeta = magnitude(ceta);
                nb = (int'(cfg.bins_in_use) > NUM_BINS) ? NUM_BINS : int'(cfg.bins_in_use);
                // first bin with the eta strictly between its edges wins
                for (k = 0; k < nb; k++)
                begin
                    lo = int'(cfg.eta_edges[EDGE_W*k +: EDGE_W]);
                    hi = int'(cfg.eta_edges[EDGE_W*(k+1) +: EDGE_W]);
                    if (!r.bin_found && lo < aeta && aeta < hi)
                    begin
                        r.eta_bin   = 2'(k);
                        r.bin_found = 1'b1;
                    end
                end
                if (magnitude(ceta - reta) <= int'(cfg.eta_cut))
                begin
                    r.cuts_passed = 3'd1;
                    if (int'(r.delta_phi) <= int'(cfg.phi_cut))
                    begin
                        r.cuts_passed = 3'd2;
                        if (r.bin_found)
                        begin
                            thr = int'(cfg.energy_thresholds[ENERGY_W*r.eta_bin +: ENERGY_W]);
                            r.cuts_passed = 3'd3;
                            if (int'(c.cluster_energy) >= thr)
                            begin
                                r.cuts_passed = 3'd4;
                                r.accept      = c.prev_passed;
                            end
                        end
                    end
                end
            end
            return r;
        endfunction

        function void note_candidate(item_t c);
            pending_results.push_back(evaluate_cut_chain(c));
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual accept=%0d cuts=%0d",
                         $time, got.accept, got.cuts_passed);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            accepted += int'(want.accept);
            depth_count[want.cuts_passed]++;
            compare_field("accept", 16'(want.accept), 16'(got.accept));
            compare_field("cuts_passed", 16'(want.cuts_passed), 16'(got.cuts_passed));
            compare_field("eta_bin", 16'(want.eta_bin), 16'(got.eta_bin));
            compare_field("bin_found", 16'(want.bin_found), 16'(got.bin_found));
            compare_field("delta_phi", 16'(want.delta_phi), 16'(got.delta_phi));
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata  = '0;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cut_scoreboard sb = new();
    int            send_idle_pct  = 37;
    int            recv_stall_pct = 88;
    int            settings_applied = 0;
    int unsigned   cycle_count = 0;

    cluster_roi_cut_selector i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #10ns clk = 1'b1;
        #10ns clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Sample both streams on the edge where each transaction completes
    always @(posedge clk)
    begin : monitor
        item_t seen_item;
        res_t  seen_res;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                seen_item.prev_passed    = s_tuser;
                seen_item.roi_eta        = s_tdata[11:0];
                seen_item.roi_phi        = s_tdata[23:12];
                seen_item.cluster_eta    = s_tdata[35:24];
                seen_item.cluster_phi    = s_tdata[47:36];
                seen_item.cluster_energy = s_tdata[62:48];
                sb.note_candidate(seen_item);
            end
            if (m_tvalid && m_tready)
            begin
                seen_res.accept      = m_tuser;
                seen_res.cuts_passed = m_tdata[2:0];
                seen_res.eta_bin     = m_tdata[4:3];
                seen_res.bin_found   = m_tdata[5];
                seen_res.delta_phi   = m_tdata[17:6];
                sb.check_result(seen_res);
            end
        end
    end

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic item_t make_item(bit p, int reta, int rphi, int ceta, int cphi, int e);
        item_t c;
        c.prev_passed    = p;
        c.roi_eta        = ETA_W'(reta);
        c.roi_phi        = PHI_W'(rphi);
        c.cluster_eta    = ETA_W'(ceta);
        c.cluster_phi    = PHI_W'(cphi);
        c.cluster_energy = ENERGY_W'(e);
        return c;
    endfunction

    // When junk is set, put random bits above the register width; the block must drop them
    function automatic logic [63:0] reg_word(logic [63:0] v, int w, bit junk);
        logic [63:0] word;
        word = v;
        if (junk)
            word = word | ({$urandom, $urandom} << w);
        return word;
    endfunction

    function automatic cfg_t random_settings(int kind);
        cfg_t s;
        int   k, e;
        bit   unsorted;
        s.roi_eta_limit = LIMIT_W'($urandom_range(0, 2047));
        s.eta_cut       = ETA_W'($urandom_range(0, 400));
        s.phi_cut       = PHI_W'($urandom_range(0, 400));
        s.bins_in_use   = BINS_W'($urandom_range(0, 7));
        if (kind == 0)
        begin
            s.roi_eta_limit = $urandom_range(0, 1) ? 11'd2047 : 11'd1280;
            s.eta_cut       = $urandom_range(0, 1) ? 12'd4095 : 12'd2560;
            s.phi_cut       = $urandom_range(0, 1) ? 12'd4095 : 12'd2048;
            s.bins_in_use   = BINS_W'($urandom_range(4, 7));
        end
        else if (kind == 1)
        begin
            s.roi_eta_limit = '0;
            s.eta_cut       = '0;
            s.phi_cut       = '0;
            s.bins_in_use   = BINS_W'($urandom_range(0, 1));
        end
        unsorted = (kind == 3) && ($urandom_range(0, 1) == 1);
        e = $urandom_range(0, 64);
        for (k = 0; k <= NUM_BINS; k++)
        begin
            if (unsorted)
                s.eta_edges[EDGE_W*k +: EDGE_W] = EDGE_W'($urandom_range(0, 1400));
            else
            begin
                s.eta_edges[EDGE_W*k +: EDGE_W] = EDGE_W'(e);
                e += $urandom_range(0, 400);
            end
        end
        for (k = 0; k < NUM_BINS; k++)
            s.energy_thresholds[ENERGY_W*k +: ENERGY_W] =
                ENERGY_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 32767)
                                                      : $urandom_range(0, 600));
        return s;
    endfunction

    // Candidate aimed at the current cuts: near the limit, near a bin edge,
    // close in eta and phi, energy around the bin threshold
    function automatic item_t shaped_candidate(cfg_t s);
        item_t c;
        int    k, ceta, reta, rphi, span, delta, thr;
        k = $urandom_range(0, NUM_BINS - 1);
        if ($urandom_range(0, 3) == 0)
        begin
            reta = int'(s.roi_eta_limit) + int'($urandom_range(0, 1));
            if ($urandom_range(0, 1))
                reta = -reta;
            ceta = reta + int'($urandom_range(0, 4)) - 2;
        end
        else
        begin
            if ($urandom_range(0, 1))
                ceta = int'(s.eta_edges[EDGE_W*k +: EDGE_W]) + int'($urandom_range(0, 2)) - 1;
            else
                ceta = int'($urandom_range(0, 1400));
            if ($urandom_range(0, 1))
                ceta = -ceta;
            span = clip(int'(s.eta_cut), 0, 200) + 2;
            reta = ceta + int'($urandom_range(0, 2 * span)) - span;
        end
        c.roi_eta     = ETA_W'(clip(reta, -2048, 2047));
        c.cluster_eta = ETA_W'(clip(ceta, -2048, 2047));
        rphi  = int'($urandom_range(0, 4095)) - 2048;
        span  = clip(int'(s.phi_cut), 0, 200) + 2;
        delta = ($urandom_range(0, 15) == 0) ? 2048 : int'($urandom_range(0, 2 * span)) - span;
        c.roi_phi     = PHI_W'(rphi);
        c.cluster_phi = PHI_W'(rphi + delta);
        thr = int'(s.energy_thresholds[ENERGY_W*k +: ENERGY_W]);
        if ($urandom_range(0, 3) == 0)
            c.cluster_energy = ENERGY_W'($urandom_range(0, 32767));
        else
            c.cluster_energy = ENERGY_W'(clip(thr + int'($urandom_range(0, 4)) - 2, 0, 32767));
        c.prev_passed = ($urandom_range(0, 4) != 0);
        return c;
    endfunction

    task automatic send_candidate(input item_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, c.cluster_energy, c.cluster_phi, c.cluster_eta, c.roi_phi, c.roi_eta};
        s_tuser  <= c.prev_passed;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Back-to-back writes are legal: the next setup phase follows the access phase
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_register(idx, value);
    endtask

    task automatic apply_settings(input cfg_t c, input bit junk);
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(REG_ROI_ETA_LIMIT, reg_word(64'(c.roi_eta_limit), LIMIT_W, junk));
        write_reg(REG_ETA_CUT, reg_word(64'(c.eta_cut), ETA_W, junk));
        write_reg(REG_PHI_CUT, reg_word(64'(c.phi_cut), PHI_W, junk));
        write_reg(REG_BINS_IN_USE, reg_word(64'(c.bins_in_use), BINS_W, junk));
        write_reg(REG_ETA_EDGES, reg_word(64'(c.eta_edges), PACK_W, junk));
        write_reg(REG_ENERGY_THRESHOLDS, reg_word(64'(c.energy_thresholds), PACK_W, junk));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        settings_applied++;
    endtask

    initial
    begin
        cfg_t  d;
        item_t c;
        int    profile, slot;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: all edges zero, so no bin can match
        send_candidate(make_item(1'b1, 0, 0, 0, 0, 0));
        send_candidate(make_item(1'b1, 665, 0, 665, 65, 32767));
        send_candidate(make_item(1'b1, -666, 0, -666, 0, 100));
        send_candidate(make_item(1'b0, 10, 10, 30, 80, 5));

        d.roi_eta_limit     = 11'd665;
        d.eta_cut           = 12'd26;
        d.phi_cut           = 12'd65;
        d.bins_in_use       = 3'd4;
        d.eta_edges         = {12'd1024, 12'd768, 12'd512, 12'd256, 12'd0};
        d.energy_thresholds = {15'd400, 15'd300, 15'd200, 15'd100};
        apply_settings(d, 1'b0);

        send_candidate(make_item(1'b1, 665, 0, 670, 0, 300));       // energy exactly at threshold
        send_candidate(make_item(1'b1, 666, 0, 670, 0, 500));       // fiducial reject
        send_candidate(make_item(1'b1, -665, 100, -640, 150, 299)); // one below threshold
        send_candidate(make_item(1'b1, -2048, 0, -2048, 0, 32767)); // most negative eta
        send_candidate(make_item(1'b1, 2047, 2047, 2047, 2047, 32767));
        send_candidate(make_item(1'b1, 100, 0, 127, 0, 500));       // eta difference one over
        send_candidate(make_item(1'b1, 100, 0, 126, 0, 500));       // eta difference at the cut
        send_candidate(make_item(1'b1, 300, 0, 300, 65, 500));      // phi difference at the cut
        send_candidate(make_item(1'b1, 300, 0, 300, -66, 500));     // phi difference one over
        send_candidate(make_item(1'b1, 300, 2047, 300, -2048, 500));// phi wraps to 1
        send_candidate(make_item(1'b1, 300, 0, 300, -2048, 500));   // half turn
        send_candidate(make_item(1'b1, 300, -1024, 300, 1024, 500));// half turn
        send_candidate(make_item(1'b1, 256, 0, 256, 0, 500));       // on an edge: no bin
        send_candidate(make_item(1'b1, 0, 0, 0, 0, 0));             // on the lowest edge
        send_candidate(make_item(1'b1, 660, 0, 1024, 0, 500));
        send_candidate(make_item(1'b1, 660, 0, 1023, 0, 500));
        send_candidate(make_item(1'b0, 300, 0, 300, 0, 500));       // earlier stage failed
        send_candidate(make_item(1'b1, -300, -2048, -300, 2047, 200));
        send_candidate(make_item(1'b1, 1, 0, -1, 0, 100));
        send_candidate(make_item(1'b0, -1, -1, -1, -1, 32767));
        send_candidate(make_item(1'b1, 665, 0, 639, 0, 0));

        for (profile = 0; profile < 3; profile++)
        begin
            case (profile)
                0:       begin send_idle_pct = 37; recv_stall_pct = 88; end
                1:       begin send_idle_pct = 88; recv_stall_pct = 37; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            for (slot = 0; slot < 4; slot++)
            begin
                apply_settings(random_settings(slot), 1'($urandom_range(0, 1)));
                repeat (128)
                begin
                    if ($urandom_range(0, 3) == 0)
                        c = {$urandom, $urandom};
                    else
                        c = shaped_candidate(sb.cfg);
                    send_candidate(c);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d candidates checked under %0d register settings, %0d accepted",
                 sb.checked, settings_applied, sb.accepted);
        $display("cuts_passed 0..4 seen: %0d %0d %0d %0d %0d", sb.depth_count[0],
                 sb.depth_count[1], sb.depth_count[2], sb.depth_count[3], sb.depth_count[4]);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
